// File: rtl/core/pwmf_pkg.sv
package pwmf_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FREQ_LOW  = 2'd1,
        ST_DUTY_HIGH = 2'd2,
        ST_UNREACH   = 2'd3
    } status_t;

    // Fine prescaler table {1,2,4,6,8,10,12,14}
    localparam logic [3:0] FINE [8] = '{4'd1, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12, 4'd14};

    // floor(390630 / fine[f]); the pair threshold is this value shifted right by the coarse index.
    // A pair qualifies when freq_q8 is above it.
    localparam logic [18:0] FINE_THR [8] = '{19'd390630, 19'd195315, 19'd97657, 19'd65105,
                                             19'd48828, 19'd39063, 19'd32552, 19'd27902};

    localparam logic [34:0] FREQ_MIN_Q8   = 35'd128;
    localparam logic [34:0] FREQ_REACH_Q8 = 35'd217;   // at or below: divisor above 1792
    localparam logic [15:0] DUTY_FULL_Q8  = 16'd25600;
    localparam logic [10:0] MAX_PRODUCT   = 11'd1792;
    localparam logic [34:0] TICK_NUM_Q8   = 35'd25600000000;
    localparam logic [25:0] RECIP_100     = 26'd42949673;  // ceil(2^32 / 100)

    // Pipeline layout
    localparam int DIV_STEPS = 17;
    localparam int S_ROW     = 1;
    localparam int S_PICK    = 2;
    localparam int S_DVS     = 3;
    localparam int S_DIV0    = 4;
    localparam int S_MUL     = S_DIV0 + DIV_STEPS;
    localparam int S_OUT     = S_MUL + 1;
    localparam int NST       = S_OUT + 1;

    // Per-beat sideband that travels with the data
    typedef struct packed {
        logic [1:0]  unit;
        status_t     status;
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [2:0]  coarse;
        logic [2:0]  fine;
    } side_t;

endpackage

// File: rtl/core/pwmf_divider.sv
module pwmf_divider
    import pwmf_pkg::*;
(
    input  logic                 clk,
    input  logic [DIV_STEPS-1:0] adv,
    input  logic [45:0]          dvs,
    output logic [DIV_STEPS-1:0] quo
);

    logic [34:0]          rem_reg [DIV_STEPS];
    logic [45:0]          dvs_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_reg [DIV_STEPS];

    // One restoring step per stage, quotient MSB first
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        localparam int SH = DIV_STEPS - 1 - k;
        logic [34:0]          rem_i;
        logic [45:0]          dvs_i;
        logic [DIV_STEPS-1:0] quo_i;
        logic [61:0]          shifted;
        logic                 ge;
        logic [34:0]          rem_next;
        logic [DIV_STEPS-1:0] quo_next;

        if (k == 0) begin : g_first
            assign rem_i = TICK_NUM_Q8;
            assign dvs_i = dvs;
            assign quo_i = '0;
        end
        else begin : g_rest
            assign rem_i = rem_reg[k-1];
            assign dvs_i = dvs_reg[k-1];
            assign quo_i = quo_reg[k-1];
        end

        always_comb
        begin
            shifted  = {16'b0, dvs_i} << SH;
            ge       = {27'b0, rem_i} >= shifted;
            rem_next = ge ? (rem_i - shifted[34:0]) : rem_i;
            quo_next = {quo_i[DIV_STEPS-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                rem_reg[k] <= rem_next;
                dvs_reg[k] <= dvs_i;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

// File: rtl/core/pwm_frequency_to_timer_settings_core.sv
// PWM timer-setting calculator: each input beat (unit, Q8 frequency, two Q8 duties) yields one
// result beat with status, coarse/fine prescaler indexes, 16-bit period and two compare values
// for a 10 ns time base. The pipeline takes one beat every clock unless in_stall is high and
// returns results in order through 23 register stages; 17 of those stages are the
// one-bit-per-stage period divider. A stalled output holds its beat while empty stages
// upstream keep filling, so input stall rises only once every stage holds a beat. Error
// results carry zero in all numeric fields.
module pwm_frequency_to_timer_settings_core
    import pwmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  instance_req,
    input  logic [34:0] freq_q8,
    input  logic [15:0] duty_a_q8,
    input  logic [15:0] duty_b_q8,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  unit,
    output logic [1:0]  status,
    output logic [2:0]  coarse_div_index,
    output logic [2:0]  fine_div_index,
    output logic [15:0] period_count,
    output logic [15:0] compare_a,
    output logic [15:0] compare_b
);

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST:0]   adv;

    side_t          side_reg [S_MUL+1];
    side_t          side0;
    side_t          side_pick;

    logic [34:0]    fq_reg [S_DVS];
    logic [63:0]    pass_next;
    logic [63:0]    pass_reg;
    logic [7:0]     row_hit_next;
    logic [7:0]     row_hit_reg;
    logic [2:0]     row_f_next [8];
    logic [2:0]     row_f_reg [8];
    logic [2:0]     pick_c;
    logic [2:0]     pick_f;
    logic [10:0]    best_p;
    logic [10:0]    row_p;
    logic           found;
    logic [45:0]    dvs_prod;
    logic [45:0]    dvs_next;
    logic [45:0]    dvs_reg;
    logic [DIV_STEPS-1:0] quo;
    logic [15:0]    period;
    logic [15:0]    period_reg;
    logic [31:0]    prod_a_reg;
    logic [31:0]    prod_b_reg;
    logic [49:0]    scale_a;
    logic [49:0]    scale_b;

    logic [1:0]     unit_reg;
    logic [1:0]     status_reg;
    logic [2:0]     coarse_reg;
    logic [2:0]     fine_reg;
    logic [15:0]    period_out_reg;
    logic [15:0]    cmp_a_reg;
    logic [15:0]    cmp_b_reg;

    // Stage advance chain: a stage loads when empty or when its beat moves on
    always_comb
    begin
        adv[NST] = !out_stall;
        for (int i = NST - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int i = 1; i < NST; i++)
        begin
            if (adv[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[S_OUT];

    // Stage 0: status checks and per-pair threshold compares
    always_comb
    begin
        side0.unit   = instance_req;
        side0.duty_a = duty_a_q8;
        side0.duty_b = duty_b_q8;
        side0.coarse = '0;
        side0.fine   = '0;
        if (freq_q8 <= FREQ_MIN_Q8)
        begin
            side0.status = ST_FREQ_LOW;
        end
        else if (duty_a_q8 > DUTY_FULL_Q8 || duty_b_q8 > DUTY_FULL_Q8)
        begin
            side0.status = ST_DUTY_HIGH;
        end
        else if (freq_q8 <= FREQ_REACH_Q8)
        begin
            side0.status = ST_UNREACH;
        end
        else
        begin
            side0.status = ST_OK;
        end
        for (int c = 0; c < 8; c++)
        begin
            for (int f = 0; f < 8; f++)
            begin
                pass_next[c*8+f] = freq_q8 > {16'b0, FINE_THR[f] >> c};
            end
        end
    end

    // Stage 1: first qualifying fine index in each coarse row
    always_comb
    begin
        for (int c = 0; c < 8; c++)
        begin
            row_hit_next[c] = |pass_reg[c*8 +: 8];
            row_f_next[c]   = '0;
            for (int f = 7; f >= 0; f--)
            begin
                if (pass_reg[c*8+f])
                begin
                    row_f_next[c] = 3'(f);
                end
            end
        end
    end

    // Stage 2: smallest product across rows, lower coarse wins a tie, else (7,7)
    always_comb
    begin
        pick_c = 3'd7;
        pick_f = 3'd7;
        best_p = MAX_PRODUCT;
        found  = 1'b0;
        row_p  = '0;
        for (int c = 0; c < 8; c++)
        begin
            row_p = {7'b0, FINE[row_f_reg[c]]} << c;
            if (row_hit_reg[c] && (!found || row_p < best_p))
            begin
                found  = 1'b1;
                best_p = row_p;
                pick_c = 3'(c);
                pick_f = row_f_reg[c];
            end
        end
        side_pick        = side_reg[S_PICK-1];
        side_pick.coarse = pick_c;
        side_pick.fine   = pick_f;
    end

    // Stage 3: divisor = freq_q8 * fine << coarse
    always_comb
    begin
        dvs_prod = {11'b0, fq_reg[S_DVS-1]} * {42'b0, FINE[side_reg[S_DVS-1].fine]};
        dvs_next = dvs_prod << side_reg[S_DVS-1].coarse;
    end

    // Stages 0..3 and sideband
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            side_reg[0] <= side0;
            fq_reg[0]   <= freq_q8;
            pass_reg    <= pass_next;
        end
        if (adv[S_ROW])
        begin
            fq_reg[S_ROW] <= fq_reg[S_ROW-1];
            row_hit_reg   <= row_hit_next;
            row_f_reg     <= row_f_next;
        end
        if (adv[S_PICK])
        begin
            fq_reg[S_PICK] <= fq_reg[S_PICK-1];
        end
        if (adv[S_DVS])
        begin
            dvs_reg <= dvs_next;
        end
        for (int i = 1; i <= S_MUL; i++)
        begin
            if (adv[i])
            begin
                side_reg[i] <= (i == S_PICK) ? side_pick : side_reg[i-1];
            end
        end
    end

    // Stages 4..20: period = floor(25.6e9 / divisor)
    pwmf_divider u_div (
        .clk (clk),
        .adv (adv[S_DIV0 +: DIV_STEPS]),
        .dvs (dvs_reg),
        .quo (quo)
    );

    // Saturate as a guard
    assign period = quo[DIV_STEPS-1] ? 16'hFFFF : quo[15:0];

    // Stage 21: period times duty
    always_ff @(posedge clk)
    begin
        if (adv[S_MUL])
        begin
            period_reg <= period;
            prod_a_reg <= {16'b0, period} * {16'b0, side_reg[S_MUL-1].duty_a};
            prod_b_reg <= {16'b0, period} * {16'b0, side_reg[S_MUL-1].duty_b};
        end
    end

    // Stage 22: divide by 25600 as >>8 then exact reciprocal multiply for /100
    always_comb
    begin
        scale_a = {26'b0, prod_a_reg[31:8]} * {24'b0, RECIP_100};
        scale_b = {26'b0, prod_b_reg[31:8]} * {24'b0, RECIP_100};
    end

    always_ff @(posedge clk)
    begin
        if (adv[S_OUT])
        begin
            unit_reg   <= side_reg[S_MUL].unit;
            status_reg <= side_reg[S_MUL].status;
            if (side_reg[S_MUL].status == ST_OK)
            begin
                coarse_reg     <= side_reg[S_MUL].coarse;
                fine_reg       <= side_reg[S_MUL].fine;
                period_out_reg <= period_reg;
                cmp_a_reg      <= scale_a[47:32];
                cmp_b_reg      <= scale_b[47:32];
            end
            else
            begin
                coarse_reg     <= '0;
                fine_reg       <= '0;
                period_out_reg <= '0;
                cmp_a_reg      <= '0;
                cmp_b_reg      <= '0;
            end
        end
    end

    assign unit             = unit_reg;
    assign status           = status_reg;
    assign coarse_div_index = coarse_reg;
    assign fine_div_index   = fine_reg;
    assign period_count     = period_out_reg;
    assign compare_a        = cmp_a_reg;
    assign compare_b        = cmp_b_reg;

    // Input backs up only when every stage holds a beat and the output is stalled
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && (&vld_reg)))
        else $error("input stalled with a free stage");

    // Error beats carry zero fields
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |->
        (period_count == 16'd0 && coarse_div_index == 3'd0 && compare_a == 16'd0))
        else $error("error beat with nonzero fields");

    // Compare values never exceed the period
    a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (compare_a <= period_count && compare_b <= period_count))
        else $error("compare above period");

endmodule

// File: test/pwmf_checker.sv
`timescale 1ns / 1ps

module pwmf_checker
    import pwmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  instance_req,
    input  logic [34:0] freq_q8,
    input  logic [15:0] duty_a_q8,
    input  logic [15:0] duty_b_q8,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  unit,
    input  logic [1:0]  status,
    input  logic [2:0]  coarse_div_index,
    input  logic [2:0]  fine_div_index,
    input  logic [15:0] period_count,
    input  logic [15:0] compare_a,
    input  logic [15:0] compare_b,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          ok_seen,
    output int          err_seen
);

    typedef struct packed {
        logic [1:0]  unit;
        logic [1:0]  status;
        logic [2:0]  coarse;
        logic [2:0]  fine;
        logic [15:0] period;
        logic [15:0] cmp_a;
        logic [15:0] cmp_b;
    } timer_set_t;

    timer_set_t expected_settings[$];

    localparam longint unsigned NS_Q8    = 64'd256000000000;
    localparam longint unsigned TICKS_Q8 = 64'd25600000000;
    localparam longint unsigned STEPDIV  = 64'd655350;

    // Compute the timer settings for one request beat
    function automatic timer_set_t calc_timer_settings(logic [1:0] u, logic [34:0] fq,
                                                       logic [15:0] da, logic [15:0] db);
        timer_set_t r;
        longint unsigned f, thr, p, pb, per;
        int bc, bf;
        r = '0;
        r.unit = u;
        f = fq;
        if (f <= 64'd128) begin
            r.status = ST_FREQ_LOW;
        end
        else if (da > 16'd25600 || db > 16'd25600) begin
            r.status = ST_DUTY_HIGH;
        end
        else if (f < (64'd1 << 24) && f * 64'd1792 * STEPDIV < NS_Q8) begin
            r.status = ST_UNREACH;
        end
        else begin
            thr = NS_Q8 / STEPDIV;
            bc = 7;
            bf = 7;
            for (int c = 0; c < 8; c++) begin
                for (int k = 0; k < 8; k++) begin
                    p = 64'(FINE[k]) << c;
                    pb = 64'(FINE[bf]) << bc;
                    if (p < pb && p * f > thr) begin
                        bc = c;
                        bf = k;
                    end
                end
            end
            p = 64'(FINE[bf]) << bc;
            per = TICKS_Q8 / (f * p);
            if (per > 64'hFFFF) per = 64'hFFFF;
            r.status = ST_OK;
            r.coarse = bc[2:0];
            r.fine = bf[2:0];
            r.period = per[15:0];
            r.cmp_a = 16'((per * da) / 64'd25600);
            r.cmp_b = 16'((per * db) / 64'd25600);
        end
        return r;
    endfunction

    assign pending = expected_settings.size();

    // Predict on accepted input beats, compare on accepted result beats
    always @(posedge clk or negedge rst_n)
    begin
        timer_set_t got, want;
        if (!rst_n) begin
            fail_count <= 0;
            results_seen <= 0;
            ok_seen <= 0;
            err_seen <= 0;
            expected_settings.delete();
        end
        else begin
            if (out_valid && !out_stall) begin
                got = '{unit, status, coarse_div_index, fine_div_index,
                        period_count, compare_a, compare_b};
                results_seen <= results_seen + 1;
                if (expected_settings.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat %h", got);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = expected_settings.pop_front();
                    if (want.status == ST_OK) ok_seen <= ok_seen + 1;
                    else err_seen <= err_seen + 1;
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("mismatch: exp u%0d s%0d c%0d f%0d p%0d a%0d b%0d, got u%0d s%0d c%0d f%0d p%0d a%0d b%0d",
                                     want.unit, want.status, want.coarse, want.fine,
                                     want.period, want.cmp_a, want.cmp_b,
                                     got.unit, got.status, got.coarse, got.fine,
                                     got.period, got.cmp_a, got.cmp_b);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_settings.push_back(calc_timer_settings(instance_req, freq_q8,
                                                                duty_a_q8, duty_b_q8));
        end
    end

endmodule

// File: test/tb_pwm_frequency_to_timer_settings_core.sv
`timescale 1ns / 1ps

module tb_pwm_frequency_to_timer_settings_core;
    import pwmf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  instance_req = '0;
    logic [34:0] freq_q8 = '0;
    logic [15:0] duty_a_q8 = '0;
    logic [15:0] duty_b_q8 = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  unit;
    logic [1:0]  status;
    logic [2:0]  coarse_div_index;
    logic [2:0]  fine_div_index;
    logic [15:0] period_count;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    int          fail_count, pending, results_seen, ok_seen, err_seen;

    int  idle_count = 0;
    bit  sink_calm = 1'b0;
    bit  sink_hold = 1'b0;
    bit  src_calm = 1'b0;

    always #10 clk = ~clk;

    pwm_frequency_to_timer_settings_core dut (.*);

    pwmf_checker checker_i (.*);

    // Watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side stall
    always @(posedge clk)
    begin
        if (sink_hold)
            out_stall <= 1'b1;
        else if (sink_calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 28);
    end

    // Long result hold-off, counted here
    initial
    begin
        wait (rst_n);
        repeat (300) @(posedge clk);
        sink_hold = 1'b1;
        repeat (120) @(posedge clk);
        sink_hold = 1'b0;
        repeat (400) @(posedge clk);
        sink_calm = 1'b1;
        repeat (400) @(posedge clk);
        sink_calm = 1'b0;
    end

    // Random frequency spread across all regions of the search
    function automatic logic [34:0] pick_freq();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 35'($urandom_range(300));
            1: return 35'($urandom_range(5000, 129));
            2: return 35'(64'($urandom) << $urandom_range(3));
            3: return 35'd25600000000 - 35'($urandom_range(1000));
            4: return 35'(64'($urandom) | (64'($urandom_range(7)) << 32));
            default: return 35'($urandom) >> $urandom_range(31);
        endcase
    endfunction

    function automatic logic [15:0] pick_duty();
        if ($urandom_range(19) == 0) return 16'($urandom);
        if ($urandom_range(9) == 0) return 16'd25600 + 16'($urandom_range(1)) - 16'd1;
        return 16'($urandom_range(25600));
    endfunction

    // Present one beat and hold it until accepted
    task automatic send_beat(logic [1:0] u, logic [34:0] f, logic [15:0] a, logic [15:0] b);
        while (!src_calm && $urandom_range(99) < 28) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        instance_req <= u;
        freq_q8 <= f;
        duty_a_q8 <= a;
        duty_b_q8 <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial
    begin
        logic [34:0] dir_freq [14];
        dir_freq = '{35'd0, 35'd128, 35'd129, 35'd216, 35'd217, 35'd218, 35'd256,
                     35'd390630, 35'd390631, 35'd27902, 35'd1000, 35'h7FFFFFFFF,
                     35'd25600000000, 35'd25600};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: boundaries of frequency, duty and instance
        foreach (dir_freq[i])
            send_beat(2'(i), dir_freq[i], 16'd12800, 16'd25600);
        send_beat(2'd3, 35'd256000, 16'd0, 16'd0);
        send_beat(2'd0, 35'd256000, 16'd25601, 16'd0);
        send_beat(2'd1, 35'd256000, 16'd0, 16'hFFFF);
        send_beat(2'd2, 35'd100, 16'hFFFF, 16'hFFFF);
        send_beat(2'd1, 35'd200, 16'hFFFF, 16'd0);
        send_beat(2'd0, 35'd1234567, 16'd25600, 16'd1);

        // Random part, with a calm stretch
        for (int n = 0; n < 1600; n++) begin
            src_calm = (n >= 900 && n < 1150);
            if (n == 600) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            send_beat(2'($urandom), pick_freq(), pick_duty(), pick_duty());
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        $display("covered %0d results: %0d ok, %0d error status", results_seen, ok_seen,
                 err_seen);
        $display("frequency limits, duty limits, instance 3 and a full pipeline hold-off");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
